/* hw/rtl/wsl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_pkg: shared types and constants of the leapfrog string stepper
// Field widths, op and register codes, value types and the window layout.
// ----------------------------------------------------------------------------
package wsl_pkg;

	localparam int VAL_W     = 18;   // signed Q2.16 displacement
	localparam int IDX_W     = 11;   // point index field
	localparam int OP_W      = 2;
	localparam int R2_W      = 17;   // unsigned Q1.16, up to 1.0
	localparam int CFG_W     = 17;   // widest register
	localparam int CFG_IDX_W = 1;

	localparam int DEF_MAX_POINTS = 2048;
	localparam int WIN_CELLS      = 3;  // j+1, j, j-1

	localparam logic [R2_W-1:0]  R2_ONE     = 17'd65536;
	localparam logic [R2_W-1:0]  R2_RESET   = 17'd26214;
	localparam logic [IDX_W-1:0] LAST_RESET = 11'd2047;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_FIRST = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_R_SQUARED  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_POINT = 1'd1;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t VAL_MAX = 18'sh1FFFF;
	localparam val_t VAL_MIN = -18'sh20000;

	// one point as it moves down the cell row
	typedef struct packed {
		val_t cur;
		val_t prev;
	} pt_t;

	// three-point stencil handed to the update unit
	typedef struct packed {
		val_t cur_next;
		val_t cur_ctr;
		val_t cur_prior;
		val_t prev_ctr;
	} win_t;

endpackage
`default_nettype wire

/* hw/rtl/wsl_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_cell: one cell of the stencil row
// Holds one point (current and previous value, index), flags
// whether it is an interior point, and hands it on to the next cell.
// ----------------------------------------------------------------------------
module wsl_cell #(
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [AW-1:0] in_idx,
	input  wsl_pkg::pt_t       in_pt,
	input  wire logic [AW-1:0] end_pt,
	output logic               out_vld,
	output logic               out_inner,
	output logic [AW-1:0]      out_idx,
	output wsl_pkg::pt_t       out_pt
);
	import wsl_pkg::*;

	logic          vld_q;
	logic          inner_q;
	logic [AW-1:0] idx_q;
	pt_t           pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			inner_q <= 1'b0;
		end else begin
			vld_q   <= in_vld;
			inner_q <= in_vld && (in_idx != '0) && (in_idx < end_pt);
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= in_idx;
		pt_q  <= in_pt;
	end

	assign out_vld   = vld_q;
	assign out_inner = inner_q;
	assign out_idx   = idx_q;
	assign out_pt    = pt_q;

endmodule
`default_nettype wire

/* hw/rtl/wsl_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_update: two-stage stencil arithmetic
// Stage 1 forms the products, stage 2 sums, rounds half up and saturates.
// Both schemes are scaled to a common 2^17 divisor.
// ----------------------------------------------------------------------------
module wsl_update #(
	parameter int AW = 11
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   go,
	input  wire logic                   first,
	input  wire logic [AW-1:0]          idx,
	input  wsl_pkg::win_t               win,
	input  wire logic [wsl_pkg::R2_W-1:0] r2,
	output logic                        wb_vld,
	output logic [AW-1:0]               wb_idx,
	output wsl_pkg::val_t               wb_cur,
	output wsl_pkg::val_t               wb_prev,
	output logic                        busy
);
	import wsl_pkg::*;

	logic signed [19:0] nb;
	logic signed [19:0] lap;
	logic signed [19:0] mx;
	logic [R2_W-1:0]    k;
	logic signed [37:0] ma_c;
	logic signed [35:0] mb_c;

	logic               vld_s1;
	logic               first_s1;
	logic [AW-1:0]      idx_s1;
	val_t               c_s1;
	val_t               p_s1;
	logic signed [37:0] ma_s1;
	logic signed [35:0] mb_s1;

	logic signed [39:0] sum;
	logic signed [39:0] rnd;
	val_t               sat;

	logic               vld_s2;
	logic [AW-1:0]      idx_s2;
	val_t               new_s2;
	val_t               old_s2;

	// first step:  c*2^17 + r2*(nb - 2c)
	// time step:   4(1-r2)c - p*2^17 + 2*r2*nb   (doubled to share the shift)
	always_comb begin
		nb   = 20'(win.cur_next) + 20'(win.cur_prior);
		lap  = nb - (20'(win.cur_ctr) <<< 1);
		mx   = first ? lap : nb;
		k    = first ? '0 : (R2_ONE - r2);
		ma_c = $signed({1'b0, r2}) * mx;
		mb_c = $signed({1'b0, k}) * win.cur_ctr;
	end

	always_comb begin
		if (first_s1)
			sum = (40'(c_s1) <<< 17) + 40'(ma_s1);
		else
			sum = (40'(mb_s1) <<< 2) - (40'(p_s1) <<< 17) + (40'(ma_s1) <<< 1);
		rnd = (sum + 40'sd65536) >>> 17;
		if (rnd > 40'(VAL_MAX))
			sat = VAL_MAX;
		else if (rnd < 40'(VAL_MIN))
			sat = VAL_MIN;
		else
			sat = rnd[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= first;
		idx_s1   <= idx;
		c_s1     <= win.cur_ctr;
		p_s1     <= win.prev_ctr;
		ma_s1    <= ma_c;
		mb_s1    <= mb_c;
		idx_s2   <= idx_s1;
		new_s2   <= sat;
		old_s2   <= c_s1;
	end

	assign wb_vld  = vld_s2;
	assign wb_idx  = idx_s2;
	assign wb_cur  = new_s2;
	assign wb_prev = old_s2;
	assign busy    = vld_s1 | vld_s2;

endmodule
`default_nettype wire

/* hw/rtl/wave_string_leapfrog_step.sv */
`default_nettype none
// Load: written into the current memory when taken. Read: the memory read
// data is registered, then moved to the output register once that is free;
// the request port stalls until then. First step / time step: one point per
// cycle through the read port of the displacement memories.
// After reset a clearing pass zeroes both memories; no request is taken until
// it ends (configuration writes are taken).
// Registers reset to r_squared = 26214 and last_point = 2047.
// ----------------------------------------------------------------------------
// wave_string_leapfrog_step: 1-D wave equation stepper for a fixed-end string
// Two displacement memories (previous, current) are swept point by point;
// a row of three cells forms the stencil and a two-stage unit updates it.
// ----------------------------------------------------------------------------
module wave_string_leapfrog_step #(
	parameter int MAX_POINTS = wsl_pkg::DEF_MAX_POINTS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [wsl_pkg::OP_W-1:0]     op,
	input  wire logic [wsl_pkg::IDX_W-1:0]    point_index,
	input  wire logic signed [wsl_pkg::VAL_W-1:0] load_value,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [wsl_pkg::VAL_W-1:0]  read_value,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic [wsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wsl_pkg::CFG_W-1:0]    cfg_data
);
	import wsl_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int XW = AW + IDX_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POINTS - 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;  // issuing sweep reads
	localparam logic [2:0] ST_DRAIN = 3'd3;  // waiting for the last write-back
	localparam logic [2:0] ST_READ  = 3'd4;  // read data waiting for output reg

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_addr_q;
	logic [AW-1:0]    rd_addr_q;
	logic             first_q;
	logic [R2_W-1:0]  r_squared_q;
	logic [IDX_W-1:0] last_point_q;

	logic             out_valid_q;
	val_t             read_value_q;
	logic             rd_oob_q;

	// request decode
	logic             in_acc;
	logic [XW-1:0]    idx_ext;
	logic             in_range;
	logic [AW-1:0]    addr_in;

	// effective configuration
	logic [R2_W-1:0]  r2_eff;
	logic [XW-1:0]    lp_ext;
	logic [AW-1:0]    end_pt;

	// memories
	val_t             cur_mem  [MAX_POINTS];
	val_t             prev_mem [MAX_POINTS];
	logic             cur_we;
	logic [AW-1:0]    cur_waddr;
	val_t             cur_wdata;
	logic             prev_we;
	logic [AW-1:0]    prev_waddr;
	val_t             prev_wdata;
	logic             cur_re;
	logic [AW-1:0]    cur_raddr;
	logic             prev_re;
	val_t             cur_rdata_q;
	val_t             prev_rdata_q;

	// sweep read tag, travels with the memory read data
	logic             rd_vld_q;
	logic [AW-1:0]    rd_idx_q;

	// cell row: entry 0 is the row input, entry i+1 the output of cell i
	logic             chain_vld [WIN_CELLS+1];
	logic [AW-1:0]    chain_idx [WIN_CELLS+1];
	pt_t              chain_pt  [WIN_CELLS+1];
	logic             cell_inner[WIN_CELLS];

	win_t             win;
	logic             wb_vld;
	logic [AW-1:0]    wb_idx;
	val_t             wb_cur;
	val_t             wb_prev;
	logic             upd_busy;
	logic             pipe_busy;
	logic             out_load;

	// ---------------------------------------------------------------- decode
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign idx_ext  = XW'(point_index);
	assign in_range = idx_ext < XW'(MAX_POINTS);
	assign addr_in  = idx_ext[AW-1:0];

	// r_squared saturates at 1.0, last_point at the last stored point
	assign r2_eff = (r_squared_q > R2_ONE) ? R2_ONE : r_squared_q;
	assign lp_ext = XW'(last_point_q);
	assign end_pt = (lp_ext > XW'(MAX_POINTS - 1)) ? LAST_ADDR : lp_ext[AW-1:0];

	// ---------------------------------------------------------- memory ports
	// Writes: clearing pass, sweep write-back, or a load request when idle.
	always_comb begin
		cur_we     = 1'b0;
		cur_waddr  = addr_in;
		cur_wdata  = load_value;
		prev_we    = 1'b0;
		prev_waddr = wb_idx;
		prev_wdata = wb_prev;
		if (state_q == ST_CLEAR) begin
			cur_we     = 1'b1;
			cur_waddr  = clr_addr_q;
			cur_wdata  = '0;
			prev_we    = 1'b1;
			prev_waddr = clr_addr_q;
			prev_wdata = '0;
		end else if (wb_vld) begin
			cur_we    = 1'b1;
			cur_waddr = wb_idx;
			cur_wdata = wb_cur;
			prev_we   = 1'b1;
		end else if (in_acc && (op == OP_LOAD) && in_range) begin
			cur_we = 1'b1;
		end
	end

	// Reads: the sweep walks 0..end_pt; a read request uses the same port.
	assign cur_re    = (state_q == ST_STEP) || (in_acc && (op == OP_READ));
	assign cur_raddr = (state_q == ST_STEP) ? rd_addr_q : addr_in;
	assign prev_re   = (state_q == ST_STEP);

	always_ff @(posedge clk) begin
		if (cur_we)
			cur_mem[cur_waddr] <= cur_wdata;
		if (cur_re)
			cur_rdata_q <= cur_mem[cur_raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_waddr] <= prev_wdata;
		if (prev_re)
			prev_rdata_q <= prev_mem[rd_addr_q];
	end

	// -------------------------------------------------------------- cell row
	// Write-back of point j lands after the sweep has read j+1 and beyond, so
	// the row always sees the old time level.
	assign chain_vld[0] = rd_vld_q;
	assign chain_idx[0] = rd_idx_q;
	assign chain_pt[0]  = '{cur: cur_rdata_q, prev: prev_rdata_q};

	for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
		wsl_cell #(
			.AW(AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (chain_vld[i]),
			.in_idx   (chain_idx[i]),
			.in_pt    (chain_pt[i]),
			.end_pt   (end_pt),
			.out_vld  (chain_vld[i+1]),
			.out_inner(cell_inner[i]),
			.out_idx  (chain_idx[i+1]),
			.out_pt   (chain_pt[i+1])
		);
	end

	// newest cell holds j+1, middle cell j, oldest cell j-1
	assign win = '{
		cur_next:  chain_pt[1].cur,
		cur_ctr:   chain_pt[2].cur,
		cur_prior: chain_pt[3].cur,
		prev_ctr:  chain_pt[2].prev
	};

	wsl_update #(
		.AW(AW)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cell_inner[1]),
		.first  (first_q),
		.idx    (chain_idx[2]),
		.win    (win),
		.r2     (r2_eff),
		.wb_vld (wb_vld),
		.wb_idx (wb_idx),
		.wb_cur (wb_cur),
		.wb_prev(wb_prev),
		.busy   (upd_busy)
	);

	assign pipe_busy = rd_vld_q || chain_vld[1] || chain_vld[2] || chain_vld[3] || upd_busy;

	// ------------------------------------------------------------- sequencer
	assign out_load = (state_q == ST_READ) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			rd_addr_q    <= '0;
			first_q      <= 1'b0;
			rd_vld_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			r_squared_q  <= R2_RESET;
			last_point_q <= LAST_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_R_SQUARED:  r_squared_q  <= cfg_data[R2_W-1:0];
					CFG_LAST_POINT: last_point_q <= cfg_data[IDX_W-1:0];
					default: ;
				endcase
			end

			rd_vld_q <= (state_q == ST_STEP);

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (op) inside
							OP_FIRST, OP_STEP: begin
								state_q   <= ST_STEP;
								rd_addr_q <= '0;
								first_q   <= (op == OP_FIRST);
							end
							OP_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_STEP: begin
					if (rd_addr_q == end_pt)
						state_q <= ST_DRAIN;
					else
						rd_addr_q <= rd_addr_q + AW'(1);
				end
				ST_DRAIN: begin
					if (!pipe_busy)
						state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_addr_q;
		if (in_acc)
			rd_oob_q <= !in_range;
		if (out_load)
			read_value_q <= rd_oob_q ? '0 : cur_rdata_q;
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

	// ------------------------------------------------------------ assertions
`ifndef SYNTH
	// an interior center always has both neighbors in the row, in order
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		cell_inner[1] |-> chain_vld[1] && chain_vld[3] &&
		(chain_idx[1] == chain_idx[2] + AW'(1)) && (chain_idx[3] == chain_idx[2] - AW'(1)))
		else $error("stencil window not contiguous");

	// interior points only travel the row during a sweep
	a_row_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_inner[0] || cell_inner[2]) |-> (state_q == ST_STEP || state_q == ST_DRAIN))
		else $error("interior point in row outside a sweep");

	// fixed ends are never rewritten by a step
	a_wb_interior: assert property (@(posedge clk) disable iff (!arst_n)
		wb_vld |-> (wb_idx != '0) && (wb_idx < end_pt))
		else $error("write-back outside the interior");

	// a taken read request waits for the output register
	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_READ) |=> (state_q == ST_READ))
		else $error("read request lost");

	// the clearing pass covers every entry before requests are taken
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> ($past(clr_addr_q) == LAST_ADDR))
		else $error("clearing pass cut short");
`endif

endmodule
`default_nettype wire
